// ----- hw/rtl/cpualu_pkg.sv -----
// ----------------------------------------------------------------------------
// cpualu_pkg
// Shared types and constants of the 8-bit CPU ALU: command codes, condition
// codes, flag bit positions and the packed request and result words.
// ----------------------------------------------------------------------------
package cpualu_pkg;

  // Operation codes carried in the command field
  typedef enum logic [5:0] {
    CMD_PASS  = 6'd0,
    CMD_INC8  = 6'd1,
    CMD_INC16 = 6'd2,
    CMD_DEC8  = 6'd3,
    CMD_DEC16 = 6'd4,
    CMD_ADD8  = 6'd5,
    CMD_ADC   = 6'd6,
    CMD_SUB   = 6'd7,
    CMD_SBC   = 6'd8,
    CMD_CP    = 6'd9,
    CMD_ADD16 = 6'd10,
    CMD_ADDSP = 6'd11,
    CMD_DAA   = 6'd12,
    CMD_RLCA  = 6'd13,
    CMD_RLA   = 6'd14,
    CMD_RRCA  = 6'd15,
    CMD_RRA   = 6'd16,
    CMD_RLC   = 6'd17,
    CMD_RRC   = 6'd18,
    CMD_RL    = 6'd19,
    CMD_RR    = 6'd20,
    CMD_SLA   = 6'd21,
    CMD_SRA   = 6'd22,
    CMD_SWAP  = 6'd23,
    CMD_SRL   = 6'd24,
    CMD_BIT   = 6'd25,
    CMD_RES   = 6'd26,
    CMD_SET   = 6'd27,
    CMD_AND   = 6'd28,
    CMD_XOR   = 6'd29,
    CMD_OR    = 6'd30,
    CMD_CPL   = 6'd31,
    CMD_SCF   = 6'd32,
    CMD_CCF   = 6'd33,
    CMD_COND  = 6'd34
  } alu_cmd_t;

  // Branch condition codes
  localparam logic [2:0] CC_UNCOND = 3'd0;
  localparam logic [2:0] CC_C      = 3'd1;
  localparam logic [2:0] CC_NC     = 3'd2;
  localparam logic [2:0] CC_Z      = 3'd3;
  localparam logic [2:0] CC_NZ     = 3'd4;

  // Flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // DAA adjust values
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_BCD_MAX = 8'h99;
  localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

  // Request word, last field in the lowest bits (72 bits)
  typedef struct packed {
    logic [3:0]  flags_in;
    logic [2:0]  cond;
    logic [2:0]  bit_sel;
    logic [15:0] stack_ptr;
    logic [15:0] second;
    logic [15:0] first;
    logic [7:0]  acc;
    logic [5:0]  command;
  } alu_req_t;

  // Result word, last field in the lowest bits (32 bits with pad)
  typedef struct packed {
    logic [2:0]  pad;
    logic        taken;
    logic [3:0]  flags_out;
    logic [7:0]  acc_out;
    logic [15:0] result;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/cpualu_core.sv -----
// ----------------------------------------------------------------------------
// cpualu_core
// Single-pass ALU datapath: decodes one request and forms the new
// destination, accumulator, flags and branch-taken bit.
// ----------------------------------------------------------------------------
module cpualu_core
  import cpualu_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [7:0]  d8;
  logic [7:0]  s8;
  logic [7:0]  a8;
  logic [3:0]  f;
  logic        cin;
  logic        cin_adc;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  sub9;
  logic [8:0]  sbc9;
  logic [4:0]  hsbc5;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;
  logic [7:0]  daa_v;
  logic        daa_c;
  logic [7:0]  sh_v;
  logic        sh_co;
  logic [7:0]  logic_v;
  logic [7:0]  bit_mask;

  assign d8  = req.first[7:0];
  assign s8  = req.second[7:0];
  assign a8  = req.acc;
  assign f   = req.flags_in;
  assign cin = f[FLAG_C];
  assign cin_adc = (req.command == CMD_ADC) ? cin : 1'b0;

  // Adders, some shared by two commands
  assign sum9   = {1'b0, d8} + {1'b0, s8} + {8'd0, cin_adc};
  assign hsum5  = {1'b0, d8[3:0]} + {1'b0, s8[3:0]} + {4'd0, cin_adc};
  assign sub9   = {1'b0, a8} - {1'b0, s8};
  assign sbc9   = {1'b0, d8} - {1'b0, s8} - {8'd0, cin};
  assign hsbc5  = {1'b0, d8[3:0]} - {1'b0, s8[3:0]} - {4'd0, cin};
  assign sum17  = {1'b0, req.first} + {1'b0, req.second};
  assign hsum13 = {1'b0, req.first[11:0]} + {1'b0, req.second[11:0]};
  assign sp_sum = req.stack_ptr + {{8{s8[7]}}, s8};
  assign sp_h5  = {1'b0, req.stack_ptr[3:0]} + {1'b0, s8[3:0]};
  assign sp_c9  = {1'b0, req.stack_ptr[7:0]} + {1'b0, s8};
  assign bit_mask = 8'd1 << req.bit_sel;

  // Decimal adjust of the accumulator
  always_comb begin
    daa_v = a8;
    daa_c = cin;
    if (f[FLAG_N]) begin
      if (f[FLAG_H]) daa_v = daa_v - DAA_LO_ADJ;
      if (cin) daa_v = daa_v - DAA_HI_ADJ;
    end else begin
      if (cin || (a8 > DAA_BCD_MAX)) begin
        daa_v = daa_v + DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (f[FLAG_H] || (a8[3:0] > DAA_DIGIT_MAX)) daa_v = daa_v + DAA_LO_ADJ;
    end
  end

  // Rotates and shifts, on the accumulator or the destination byte
  always_comb begin
    sh_v  = d8;
    sh_co = 1'b0;
    case (req.command)
      CMD_RLCA: begin sh_co = a8[7]; sh_v = {a8[6:0], a8[7]}; end
      CMD_RLA:  begin sh_co = a8[7]; sh_v = {a8[6:0], cin}; end
      CMD_RRCA: begin sh_co = a8[0]; sh_v = {a8[0], a8[7:1]}; end
      CMD_RRA:  begin sh_co = a8[0]; sh_v = {cin, a8[7:1]}; end
      CMD_RLC:  begin sh_co = d8[7]; sh_v = {d8[6:0], d8[7]}; end
      CMD_RRC:  begin sh_co = d8[0]; sh_v = {d8[0], d8[7:1]}; end
      CMD_RL:   begin sh_co = d8[7]; sh_v = {d8[6:0], cin}; end
      CMD_RR:   begin sh_co = d8[0]; sh_v = {cin, d8[7:1]}; end
      CMD_SLA:  begin sh_co = d8[7]; sh_v = {d8[6:0], 1'b0}; end
      CMD_SRA:  begin sh_co = d8[0]; sh_v = {d8[7], d8[7:1]}; end
      CMD_SWAP: begin sh_co = 1'b0;  sh_v = {d8[3:0], d8[7:4]}; end
      CMD_SRL:  begin sh_co = d8[0]; sh_v = {1'b0, d8[7:1]}; end
      default:  begin sh_co = 1'b0;  sh_v = d8; end
    endcase
  end

  // Bitwise logic on the accumulator
  always_comb begin
    case (req.command)
      CMD_AND: logic_v = a8 & s8;
      CMD_XOR: logic_v = a8 ^ s8;
      default: logic_v = a8 | s8;
    endcase
  end

  // Select the outputs per command
  always_comb begin
    rsp           = '0;
    rsp.result    = req.first;
    rsp.acc_out   = a8;
    rsp.flags_out = f;
    rsp.taken     = 1'b0;
    case (req.command)
      CMD_PASS: rsp.result = req.second;
      CMD_INC8: begin
        rsp.result = {8'd0, d8 + 8'd1};
        rsp.flags_out[FLAG_Z] = (d8 == 8'hff);
        rsp.flags_out[FLAG_N] = 1'b0;
        rsp.flags_out[FLAG_H] = (d8[3:0] == 4'hf);
      end
      CMD_INC16: rsp.result = req.first + 16'd1;
      CMD_DEC8: begin
        rsp.result = {8'd0, d8 - 8'd1};
        rsp.flags_out[FLAG_Z] = (d8 == 8'h01);
        rsp.flags_out[FLAG_N] = 1'b1;
        rsp.flags_out[FLAG_H] = (d8[3:0] == 4'h0);
      end
      CMD_DEC16: rsp.result = req.first - 16'd1;
      CMD_ADD8, CMD_ADC: begin
        rsp.result = {8'd0, sum9[7:0]};
        rsp.flags_out = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4], sum9[8]};
      end
      CMD_SUB, CMD_CP: begin
        rsp.flags_out = {(sub9[7:0] == 8'd0), 1'b1, (a8[3:0] < s8[3:0]), sub9[8]};
        if (req.command == CMD_SUB) rsp.acc_out = sub9[7:0];
      end
      CMD_SBC: begin
        rsp.result = {8'd0, sbc9[7:0]};
        rsp.flags_out = {(sbc9[7:0] == 8'd0), 1'b1, hsbc5[4], sbc9[8]};
      end
      CMD_ADD16: begin
        rsp.result = sum17[15:0];
        rsp.flags_out[FLAG_N] = 1'b0;
        rsp.flags_out[FLAG_H] = hsum13[12];
        rsp.flags_out[FLAG_C] = sum17[16];
      end
      CMD_ADDSP: begin
        rsp.result = sp_sum;
        rsp.flags_out = {1'b0, 1'b0, sp_h5[4], sp_c9[8]};
      end
      CMD_DAA: begin
        rsp.acc_out = daa_v;
        rsp.flags_out = {(daa_v == 8'd0), f[FLAG_N], 1'b0, daa_c};
      end
      CMD_RLCA, CMD_RLA, CMD_RRCA, CMD_RRA: begin
        rsp.acc_out = sh_v;
        rsp.flags_out = {3'b000, sh_co};
      end
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL: begin
        rsp.result = {8'd0, sh_v};
        rsp.flags_out = {(sh_v == 8'd0), 2'b00, sh_co};
      end
      CMD_BIT: begin
        rsp.flags_out[FLAG_Z] = ((d8 & bit_mask) == 8'd0);
        rsp.flags_out[FLAG_N] = 1'b0;
        rsp.flags_out[FLAG_H] = 1'b1;
      end
      CMD_RES: rsp.result = {8'd0, d8 & ~bit_mask};
      CMD_SET: rsp.result = {8'd0, d8 | bit_mask};
      CMD_AND, CMD_XOR, CMD_OR: begin
        rsp.acc_out = logic_v;
        rsp.flags_out = {(logic_v == 8'd0), 1'b0, (req.command == CMD_AND), 1'b0};
      end
      CMD_CPL: begin
        rsp.acc_out = ~a8;
        rsp.flags_out[FLAG_N] = 1'b1;
        rsp.flags_out[FLAG_H] = 1'b1;
      end
      CMD_SCF: rsp.flags_out = {f[FLAG_Z], 2'b00, 1'b1};
      CMD_CCF: rsp.flags_out = {f[FLAG_Z], 2'b00, ~cin};
      CMD_COND: begin
        case (req.cond)
          CC_UNCOND: rsp.taken = 1'b1;
          CC_C:      rsp.taken = cin;
          CC_NC:     rsp.taken = ~cin;
          CC_Z:      rsp.taken = f[FLAG_Z];
          CC_NZ:     rsp.taken = ~f[FLAG_Z];
          default:   rsp.taken = 1'b0;
        endcase
      end
      default: rsp.taken = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/eight_bit_cpu_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags
// 8-bit CPU ALU with flags: a request register, one pass of ALU logic and a
// result register, streaming in and out.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Width  Contents
//  in_*     in   72     command, acc, first, second, stack_ptr, bit_sel,
//                       cond, flags_in
//  out_*    out  32     result, acc_out, flags_out, taken
//
//  One request per cycle while out_tready is high; an accepted request passes
//  through the request register, then the result register, before
//  out_tvalid rises. A single ALU pass lies between the two registers.
//  rst_n (synchronous, active low) empties both stages.
//  When out_tready is low with a result waiting both stages hold; in_tready
//  drops only once both stages are full.
//
module eight_bit_cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[5:0], acc[13:6], first[29:14], second[45:30], stack_ptr[61:46],
  // bit_sel[64:62], cond[67:65], flags_in[71:68]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result[15:0], acc_out[23:16], flags_out[27:24], taken[28], zero[31:29]
  output logic [31:0] out_tdata
);

  alu_req_t req_r;
  logic     req_v_r;
  logic     req_v_nxt;
  alu_rsp_t rsp_r;
  alu_rsp_t rsp_nxt;
  logic     rsp_v_r;
  logic     rsp_v_nxt;
  logic     advance;
  logic     in_take;

  // Advance when the result register is empty or being drained
  assign advance   = !rsp_v_r || out_tready;
  assign in_tready = !req_v_r || advance;
  assign in_take   = in_tvalid && in_tready;

  cpualu_core u_core (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  // Next valid state of both stages
  always_comb begin
    req_v_nxt = req_v_r;
    rsp_v_nxt = rsp_v_r;
    if (advance) begin
      rsp_v_nxt = req_v_r;
      req_v_nxt = 1'b0;
    end
    if (in_take) req_v_nxt = 1'b1;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      rsp_v_r <= 1'b0;
    end else begin
      req_v_r <= req_v_nxt;
      rsp_v_r <= rsp_v_nxt;
    end
  end

  // Payload registers: capture request, load result on advance
  always_ff @(posedge clk) begin
    if (in_take) req_r <= alu_req_t'(in_tdata);
    if (advance && req_v_r) rsp_r <= rsp_nxt;
  end

  assign out_tvalid = rsp_v_r;
  assign out_tdata  = rsp_r;

  // A stalled request holds while the result waits
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    req_v_r && rsp_v_r && !out_tready |=> req_v_r && $stable(req_r))
    else $error("request stage changed under stall");

  // Input stalls only when both stages are occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> req_v_r && rsp_v_r)
    else $error("in_tready low with a free stage");

  // Branch-taken only comes from a condition test
  a_taken_cond: assert property (@(posedge clk) disable iff (!rst_n)
    advance && req_v_r |=> !rsp_r.taken || $past(req_r.command) == CMD_COND)
    else $error("taken set for a non-condition command");

  // A delivered result is replaced by the request behind it, or the stage empties
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_v_r && out_tready && !req_v_r |=> !rsp_v_r)
    else $error("result repeated after delivery");

endmodule
